// ----- src/alc_pkg.sv -----
// shared constants and types for the array list with cursor
package alc_pkg;

  localparam int unsigned ListDepth   = 16;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned AddrWidth   = $clog2(ListDepth);
  localparam int unsigned CntWidth    = $clog2(ListDepth + 1);
  localparam int unsigned CurWidth    = CntWidth + 1;

  localparam int unsigned KindWidth   = 3;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned InDataWidth  = 32;
  localparam int unsigned OutDataWidth = 40;

  typedef enum logic [KindWidth-1:0] {
    KIND_INSERT = 3'd0,
    KIND_FIRST  = 3'd1,
    KIND_NEXT   = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_COUNT  = 3'd4
  } kind_e;

endpackage

// ----- src/array_list_with_cursor.sv -----
// ordered list of data words with a read cursor, one operation per request
//
//   channel  dir  tdata                                   tuser
//   s_axis   in   [31:0] value_in                         [2:0] kind
//   m_axis   out  [31:0] value_out, [36:32] entry_count   [0] ok
//
// insert, count and failed requests go from accept straight to the result state;
// first and next pass through one entry ram read, and remove reads the entry at
// the cursor, then moves each entry behind it down one ram write at a time.
// the input side is ready only while no request is in work; a result waits
// in the output register while the next request is accepted.
// reset clears the count and puts the cursor at no position; the ram is not cleared.
module array_list_with_cursor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [alc_pkg::InDataWidth-1:0]  s_axis_tdata,  // value_in
  input  logic [alc_pkg::KindWidth-1:0]    s_axis_tuser,  // kind
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [alc_pkg::OutDataWidth-1:0] m_axis_tdata,  // value_out, entry_count, zero pad
  output logic                             m_axis_tuser   // ok
);

  import alc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_RESP  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CntWidth-1:0]        cnt_q, cnt_d;
  logic signed [CurWidth-1:0] cur_q, cur_d;
  logic [CntWidth-1:0]        idx_q, idx_d;
  logic                       rm_q, rm_d;
  logic                       res_ok_q, res_ok_d;
  logic [ValueWidth-1:0]      res_val_q, res_val_d;

  logic                       m_valid_q, m_valid_d;
  logic                       m_ok_q, m_ok_d;
  logic [ValueWidth-1:0]      m_val_q, m_val_d;
  logic [CountWidth-1:0]      m_cnt_q, m_cnt_d;

  logic                       ram_we;
  logic [AddrWidth-1:0]       ram_waddr;
  logic [DataWidth-1:0]       ram_wdata;
  logic [AddrWidth-1:0]       ram_raddr;
  logic [DataWidth-1:0]       ram_rdata;

  logic signed [CurWidth-1:0] cnt_s;
  logic signed [CurWidth-1:0] cur_inc;
  logic signed [CurWidth-1:0] cur_nxt;
  logic                       cur_valid;
  logic                       nxt_valid;
  logic [CntWidth:0]          idx_p1;
  logic [CntWidth:0]          idx_p2;
  logic [CntWidth:0]          cnt_x;
  logic [DataWidth-1:0]       word_in;
  logic [ValueWidth-1:0]      word_out;

  alc_ram #(
    .Width(DataWidth),
    .Depth(ListDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cnt_s     = signed'({1'b0, cnt_q});
  assign cur_inc   = cur_q + CurWidth'(1);
  assign cur_nxt   = (cur_q < cnt_s) ? cur_inc : cur_q;
  assign cur_valid = !cur_q[CurWidth-1] && (cur_q[CntWidth-1:0] < cnt_q);
  assign nxt_valid = !cur_nxt[CurWidth-1] && (cur_nxt[CntWidth-1:0] < cnt_q);
  assign cnt_x     = {1'b0, cnt_q};
  assign idx_p1    = {1'b0, idx_q} + (CntWidth+1)'(1);
  assign idx_p2    = {1'b0, idx_q} + (CntWidth+1)'(2);
  assign word_in   = DataWidth'(64'(s_axis_tdata));
  assign word_out  = ValueWidth'(64'(ram_rdata));

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    rm_d      = rm_q;
    res_ok_d  = res_ok_q;
    res_val_d = res_val_q;
    m_valid_d = m_valid_q;
    m_ok_d    = m_ok_q;
    m_val_d   = m_val_q;
    m_cnt_d   = m_cnt_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AddrWidth-1:0];
    ram_wdata = word_in;
    ram_raddr = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          rm_d      = 1'b0;
          res_ok_d  = 1'b0;
          res_val_d = '0;
          state_d   = ST_RESP;
          unique case (kind_e'(s_axis_tuser))
            KIND_INSERT: begin
              if (cnt_q < CntWidth'(ListDepth)) begin
                ram_we   = 1'b1;
                cnt_d    = cnt_q + CntWidth'(1);
                res_ok_d = 1'b1;
              end
            end
            KIND_FIRST: begin
              if (cnt_q != '0) begin
                cur_d     = '0;
                ram_raddr = '0;
                res_ok_d  = 1'b1;
                state_d   = ST_READ;
              end
            end
            KIND_NEXT: begin
              cur_d = cur_nxt;
              if (nxt_valid) begin
                ram_raddr = cur_nxt[AddrWidth-1:0];
                res_ok_d  = 1'b1;
                state_d   = ST_READ;
              end
            end
            KIND_REMOVE: begin
              if (cur_valid) begin
                ram_raddr = cur_q[AddrWidth-1:0];
                idx_d     = cur_q[CntWidth-1:0];
                rm_d      = 1'b1;
                res_ok_d  = 1'b1;
                state_d   = ST_READ;
              end
            end
            KIND_COUNT: begin
              res_ok_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        res_val_d = word_out;
        state_d   = ST_RESP;
        if (rm_q) begin
          if (idx_p1 < cnt_x) begin
            // fetch the first entry to move down
            ram_raddr = idx_p1[AddrWidth-1:0];
            state_d   = ST_SHIFT;
          end else begin
            cnt_d = cnt_q - CntWidth'(1);
            cur_d = cur_q - CurWidth'(1);
          end
        end
      end
      ST_SHIFT: begin
        // entry idx+1 is on the read port, store it one place down
        ram_we    = 1'b1;
        ram_waddr = idx_q[AddrWidth-1:0];
        ram_wdata = ram_rdata;
        idx_d     = idx_p1[CntWidth-1:0];
        ram_raddr = idx_p2[AddrWidth-1:0];
        if (!(idx_p2 < cnt_x)) begin
          cnt_d   = cnt_q - CntWidth'(1);
          cur_d   = cur_q - CurWidth'(1);
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_ok_d    = res_ok_q;
          m_val_d   = res_val_q;
          m_cnt_d   = CountWidth'(cnt_q);
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cur_q     <= '1;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cur_q     <= cur_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    rm_q      <= rm_d;
    res_ok_q  <= res_ok_d;
    res_val_q <= res_val_d;
    m_ok_q    <= m_ok_d;
    m_val_q   <= m_val_d;
    m_cnt_q   <= m_cnt_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_ok_q;
  assign m_axis_tdata  = {{(OutDataWidth-ValueWidth-CountWidth){1'b0}}, m_cnt_q, m_val_q};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntWidth'(ListDepth))
    else $error("entry count above list depth");

  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q[CurWidth-1] && (cur_q == '1)) ||
    (!cur_q[CurWidth-1] && (cur_q[CntWidth-1:0] <= cnt_q)))
    else $error("cursor outside minus one to count");

  a_shift_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (idx_p1 < cnt_x))
    else $error("shift reads past the last entry");

  a_shift_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |=> ((state_q == ST_RESP) || $stable(cnt_q)))
    else $error("count changed in the middle of a remove");
`endif

endmodule

// ----- src/alc_ram.sv -----
// generic single write port ram with registered read
module alc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/sv/tb_array_list_with_cursor.sv -----
// testbench for the array list with cursor: random list operations checked against a shadow list
module tb_array_list_with_cursor;
  timeunit 1ns;
  timeprecision 1ps;

  import alc_pkg::*;

  typedef struct packed {
    logic [KindWidth-1:0]   kind;
    logic [InDataWidth-1:0] word;
  } list_op_t;

  typedef struct packed {
    logic                  ok;
    logic [ValueWidth-1:0] value;
    logic [CountWidth-1:0] count;
  } list_reply_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;   // value_in
  logic [KindWidth-1:0]    s_axis_tuser = '0;   // kind
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;        // value_out, entry_count, zero pad
  logic                    m_axis_tuser;        // ok

  list_op_t    pending_ops[$];
  list_reply_t predicted_replies[$];
  list_op_t    send_op;
  list_reply_t want;
  int          total_ops = 0;
  int          ops_accepted = 0;
  int          error_count = 0;
  int unsigned cycle_no = 0;

  // shadow copy of the list contents, count and cursor
  logic [DataWidth-1:0] shadow_words[ListDepth];
  int                   shadow_count = 0;
  int                   shadow_cursor = -1;

  array_list_with_cursor uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
  end

  // the first quarter of each repeating period of the cycle counter runs with no gaps at all
  function automatic bit take_break();
    return (cycle_no % 6000) >= 1500 && $urandom_range(0, 99) < 13;
  endfunction

  function automatic list_reply_t apply_list_op(logic [KindWidth-1:0] kind,
                                                logic [InDataWidth-1:0] word);
    list_reply_t r;
    r = '0;
    case (kind)
      KIND_INSERT: begin
        if (shadow_count < ListDepth) begin
          shadow_words[shadow_count] = word[DataWidth-1:0];
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      KIND_FIRST: begin
        if (shadow_count > 0) begin
          shadow_cursor = 0;
          r.value = shadow_words[0];
          r.ok = 1'b1;
        end
      end
      KIND_NEXT: begin
        // cursor saturates at the count, one past the last entry
        if (shadow_cursor < shadow_count) shadow_cursor++;
        if (shadow_cursor >= 0 && shadow_cursor < shadow_count) begin
          r.value = shadow_words[shadow_cursor];
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (shadow_cursor >= 0 && shadow_cursor < shadow_count) begin
          r.value = shadow_words[shadow_cursor];
          for (int i = shadow_cursor; i < shadow_count - 1; i++) begin
            shadow_words[i] = shadow_words[i + 1];
          end
          shadow_count--;
          shadow_cursor--;
          r.ok = 1'b1;
        end
      end
      KIND_COUNT: begin
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.count = shadow_count[CountWidth-1:0];
    return r;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_ops.size() != 0 && !take_break()) begin
        send_op = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= send_op.word;
        s_axis_tuser  <= send_op.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !take_break();
    end
  end

  // result checker, then prediction for the request taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual ok=%b value=%h count=%0d",
                   $time, m_axis_tuser, m_axis_tdata[ValueWidth-1:0],
                   m_axis_tdata[ValueWidth +: CountWidth]);
          error_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (m_axis_tuser !== want.ok) begin
            $display("%0t: ok mismatch, expected %b actual %b", $time, want.ok, m_axis_tuser);
            error_count++;
          end
          if (m_axis_tdata[ValueWidth-1:0] !== want.value) begin
            $display("%0t: value_out mismatch, expected %h actual %h", $time, want.value,
                     m_axis_tdata[ValueWidth-1:0]);
            error_count++;
          end
          if (m_axis_tdata[ValueWidth +: CountWidth] !== want.count) begin
            $display("%0t: entry_count mismatch, expected %0d actual %0d", $time, want.count,
                     m_axis_tdata[ValueWidth +: CountWidth]);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_replies.push_back(apply_list_op(s_axis_tuser, s_axis_tdata));
        ops_accepted++;
      end
    end
  end

  task automatic queue_op(logic [KindWidth-1:0] kind, logic [InDataWidth-1:0] word);
    pending_ops.push_back('{kind: kind, word: word});
    total_ops++;
  endtask

  initial begin
    int                   counted;
    int                   mode;
    int                   roll;
    logic [KindWidth-1:0] kind_pick;

    // empty list: every cursor operation fails
    queue_op(KIND_REMOVE, $urandom);
    queue_op(KIND_NEXT, $urandom);
    queue_op(KIND_FIRST, $urandom);
    queue_op(KIND_COUNT, $urandom);
    queue_op(3'd7, $urandom);
    // fill to the top, extremes of the word first
    queue_op(KIND_INSERT, '0);
    queue_op(KIND_INSERT, '1);
    for (int i = 2; i < ListDepth; i++) queue_op(KIND_INSERT, $urandom);
    queue_op(KIND_INSERT, $urandom);  // full
    // remove at entry 0 shifts the whole list, then no cursor is left
    queue_op(KIND_FIRST, $urandom);
    queue_op(KIND_REMOVE, $urandom);
    queue_op(KIND_REMOVE, $urandom);
    queue_op(KIND_NEXT, $urandom);
    queue_op(KIND_COUNT, $urandom);

    counted = 0;
    while (counted < 1250) begin
      mode = $urandom_range(0, 3);
      repeat (40) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 2) begin
          kind_pick = 3'($urandom_range(5, 7));
        end else begin
          case (mode)
            0: kind_pick = roll < 70 ? KIND_INSERT : roll < 80 ? KIND_NEXT :
                           roll < 88 ? KIND_FIRST : roll < 95 ? KIND_REMOVE : KIND_COUNT;
            1: kind_pick = roll < 10 ? KIND_INSERT : roll < 25 ? KIND_FIRST :
                           roll < 50 ? KIND_NEXT : roll < 95 ? KIND_REMOVE : KIND_COUNT;
            2: kind_pick = roll < 15 ? KIND_INSERT : roll < 30 ? KIND_FIRST :
                           roll < 80 ? KIND_NEXT : roll < 90 ? KIND_REMOVE : KIND_COUNT;
            default: kind_pick = roll < 30 ? KIND_INSERT : roll < 45 ? KIND_FIRST :
                                 roll < 65 ? KIND_NEXT : roll < 90 ? KIND_REMOVE : KIND_COUNT;
          endcase
          counted++;
        end
        queue_op(kind_pick, $urandom);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ops_accepted < total_ops) @(posedge clk_i);
    while (predicted_replies.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
